>>> sv/rac_pkg.sv
// Shared types and constants for the RESP array command parser.
// Event kinds, error codes, protocol characters and the number unit's
// control and status structs. No dependencies.
package rac_pkg;

    // Width of counts, lengths and argument indexes
    localparam int NUM_W = 31;
    typedef logic [NUM_W-1:0] t_num;

    // Event kinds carried on the result channel
    typedef enum logic [2:0] {
        EV_HEADER    = 3'd0,
        EV_ARG_START = 3'd1,
        EV_ARG_DATA  = 3'd2,
        EV_ARG_END   = 3'd3,
        EV_ERROR     = 3'd4
    } t_event_kind;

    // Error codes reported with EV_ERROR
    typedef enum logic [2:0] {
        ERR_NO_ARRAY   = 3'd0,
        ERR_NO_BULK    = 3'd1,
        ERR_NEG_LENGTH = 3'd2,
        ERR_BAD_CRLF   = 3'd3,
        ERR_LINE_LONG  = 3'd4,
        ERR_OVERFLOW   = 3'd5
    } t_err_code;

    // Protocol and whitespace characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Magnitude limits of a parsed number
    localparam logic [34:0] MAG_MAX_POS = 35'h0_7FFF_FFFF;
    localparam logic [34:0] MAG_MAX_NEG = 35'h0_8000_0000;

    // Control from the sequencer to the number unit
    typedef struct packed {
        logic       clear;
        logic       feed;
        logic [7:0] data;
    } t_num_ctrl;

    // Status from the number unit to the sequencer
    typedef struct packed {
        logic [31:0] acc;
        logic        neg;
        logic        err;
        t_err_code   err_code;
    } t_num_stat;

endpackage

>>> sv/rac_if.sv
// Valid/ready channel interfaces for the RESP array command parser.
// Byte input channel and event output channel; depends on nothing.
interface rac_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rac_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [30:0] number_value;
    logic [7:0]  payload_byte;
    logic [30:0] arg_index;
    logic        command_done;
    logic [2:0]  error_code;

    modport source (
        output valid, output event_kind, output number_value, output payload_byte,
        output arg_index, output command_done, output error_code, input ready
    );
    modport sink (
        input valid, input event_kind, input number_value, input payload_byte,
        input arg_index, input command_done, input error_code, output ready
    );
endinterface

>>> sv/rac_number.sv
// Number line accumulator: atoi-style parse of one count or length line.
// Holds line length, magnitude, sign and parse subphase.
// Depends on rac_pkg.
module rac_number import rac_pkg::*; #(
    parameter int LINE_BUFFER_BYTES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_num_ctrl i_ctrl,
    output t_num_stat o_stat
);

    localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
    localparam logic [LEN_W-1:0] LINE_MAX = LEN_W'(LINE_BUFFER_BYTES - 1);

    typedef enum logic [1:0] {
        NS_SPACE  = 2'd0,
        NS_DIGITS = 2'd1,
        NS_STOP   = 2'd2
    } t_sub;

    logic [LEN_W-1:0] r_len, n_len;
    logic [31:0]      r_acc, n_acc;
    logic             r_neg, n_neg;
    t_sub             r_sub, n_sub;

    logic        is_space, is_sign, is_digit, in_digits, full, overflow;
    logic [34:0] acc_x10, mag;

    // Classify the byte
    always_comb begin
        is_space = (i_ctrl.data == CH_SPACE) || (i_ctrl.data == CH_TAB)
                || (i_ctrl.data == CH_LF) || (i_ctrl.data == CH_VT)
                || (i_ctrl.data == CH_FF);
        is_sign  = (i_ctrl.data == CH_PLUS) || (i_ctrl.data == CH_MINUS);
        is_digit = (i_ctrl.data >= CH_ZERO) && (i_ctrl.data <= CH_NINE);
    end

    // Multiply by ten as two shifts and add, then check the signed limit
    always_comb begin
        in_digits = (r_sub == NS_DIGITS) || ((r_sub == NS_SPACE) && !is_space && !is_sign);
        acc_x10   = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0};
        mag       = acc_x10 + {31'd0, i_ctrl.data[3:0]};
        full      = (r_len >= LINE_MAX);
        overflow  = in_digits && is_digit && (mag > (r_neg ? MAG_MAX_NEG : MAG_MAX_POS));
    end

    // Next number state for a fed byte
    always_comb begin
        n_len = r_len + LEN_W'(1);
        n_acc = r_acc;
        n_neg = r_neg;
        n_sub = r_sub;
        if ((r_sub == NS_SPACE) && is_sign) begin
            n_neg = (i_ctrl.data == CH_MINUS);
            n_sub = NS_DIGITS;
        end else if (in_digits) begin
            if (is_digit) begin
                n_acc = mag[31:0];
                n_sub = NS_DIGITS;
            end else begin
                n_sub = NS_STOP;
            end
        end
    end

    // Hold, clear or advance the number state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_len <= '0;
            r_acc <= '0;
            r_neg <= 1'b0;
            r_sub <= NS_SPACE;
        end else if (i_ctrl.feed && !full && !overflow) begin
            r_len <= n_len;
            r_acc <= n_acc;
            r_neg <= n_neg;
            r_sub <= n_sub;
        end
    end

    // Report the value and any fault the current byte would raise
    always_comb begin
        o_stat.acc      = r_acc;
        o_stat.neg      = r_neg;
        o_stat.err      = full || overflow;
        o_stat.err_code = full ? ERR_LINE_LONG : ERR_OVERFLOW;
    end

endmodule

>>> sv/resp_array_command_parser.sv
// RESP array-of-bulk-strings command parser, top level.
// Depends on rac_pkg, rac_if (rac_byte_if, rac_event_if) and rac_number.
//
//  channel  | dir | interface    | payload
//  ---------+-----+--------------+----------------------------------------------
//  i_in     | in  | rac_byte_if  | data_byte
//  o_out    | out | rac_event_if | event_kind, number_value, payload_byte,
//           |     |              | arg_index, command_done, error_code
//
// One byte per clock unless the input is stalled: each accepted byte updates the parse
// state and, when it causes an event, loads the single output register in the same cycle.
// The event is presented in the cycle after its byte. Input is stalled only while the
// output register holds an event that is not being taken.
// Reset (i_rst_n low, synchronous) returns the parser to waiting for '*' and
// clears any sticky error.
module resp_array_command_parser import rac_pkg::*; #(
    parameter int LINE_BUFFER_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rac_byte_if.sink    i_in,
    rac_event_if.source o_out
);

    typedef enum logic [3:0] {
        PH_STAR   = 4'd0,
        PH_CLINE  = 4'd1,
        PH_CLF    = 4'd2,
        PH_DOLLAR = 4'd3,
        PH_LLINE  = 4'd4,
        PH_LLF    = 4'd5,
        PH_DATA   = 4'd6,
        PH_DCR    = 4'd7,
        PH_DLF    = 4'd8,
        PH_ERROR  = 4'd9
    } t_phase;

    t_phase r_phase, n_phase;
    t_num   r_args_total, n_args_total;
    t_num   r_cur_arg, n_cur_arg;
    t_num   r_bytes_left, n_bytes_left;

    logic        r_out_valid;
    t_event_kind r_kind, n_kind;
    t_num        r_num, n_num;
    logic [7:0]  r_pay, n_pay;
    t_num        r_idx, n_idx;
    logic        r_done, n_done;
    t_err_code   r_err, n_err;
    logic        n_emit;

    logic       accept;
    logic [7:0] data;
    t_num       next_arg;
    t_num       left_dec;
    t_num_ctrl  num_ctrl;
    t_num_stat  num_stat;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign data       = i_in.data_byte;
    assign next_arg   = r_cur_arg + NUM_W'(1);
    assign left_dec   = r_bytes_left - NUM_W'(1);

    // Drive the number unit: clear on a marker, feed every non-CR line byte
    always_comb begin
        num_ctrl.data  = data;
        num_ctrl.clear = accept && (((r_phase == PH_STAR) && (data == CH_STAR))
                      || ((r_phase == PH_DOLLAR) && (data == CH_DOLLAR)));
        num_ctrl.feed  = accept && ((r_phase == PH_CLINE) || (r_phase == PH_LLINE))
                      && (data != CH_CR);
    end

    rac_number #(
        .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
    ) u_number (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (num_ctrl),
        .o_stat (num_stat)
    );

    // Advance the parse phase and build the event for this byte
    always_comb begin
        n_phase      = r_phase;
        n_args_total = r_args_total;
        n_cur_arg    = r_cur_arg;
        n_bytes_left = r_bytes_left;
        n_emit       = 1'b0;
        n_kind       = EV_ERROR;
        n_num        = '0;
        n_pay        = '0;
        n_idx        = r_cur_arg;
        n_done       = 1'b0;
        n_err        = ERR_NO_ARRAY;
        unique case (r_phase)
            PH_STAR: begin
                if (data != CH_STAR) begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_err   = ERR_NO_ARRAY;
                end else begin
                    n_phase = PH_CLINE;
                end
            end
            PH_DOLLAR: begin
                if (data != CH_DOLLAR) begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_err   = ERR_NO_BULK;
                end else begin
                    n_phase = PH_LLINE;
                end
            end
            PH_CLINE, PH_LLINE: begin
                if (data == CH_CR) begin
                    n_phase = (r_phase == PH_CLINE) ? PH_CLF : PH_LLF;
                end else if (num_stat.err) begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_err   = num_stat.err_code;
                end
            end
            PH_CLF: begin
                if (data != CH_LF) begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_err   = ERR_BAD_CRLF;
                end else begin
                    n_cur_arg = '0;
                    n_emit    = 1'b1;
                    n_kind    = EV_HEADER;
                    n_idx     = '0;
                    n_err     = ERR_NO_ARRAY;
                    if (num_stat.neg || (num_stat.acc == '0)) begin
                        n_args_total = '0;
                        n_phase      = PH_STAR;
                        n_done       = 1'b1;
                    end else begin
                        n_args_total = num_stat.acc[NUM_W-1:0];
                        n_phase      = PH_DOLLAR;
                        n_num        = num_stat.acc[NUM_W-1:0];
                    end
                end
            end
            PH_LLF: begin
                if (data != CH_LF) begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_err   = ERR_BAD_CRLF;
                end else if (num_stat.neg && (num_stat.acc != '0)) begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_err   = ERR_NEG_LENGTH;
                end else begin
                    n_bytes_left = num_stat.acc[NUM_W-1:0];
                    n_phase      = (num_stat.acc[NUM_W-1:0] == '0) ? PH_DCR : PH_DATA;
                    n_emit       = 1'b1;
                    n_kind       = EV_ARG_START;
                    n_num        = num_stat.acc[NUM_W-1:0];
                end
            end
            PH_DATA: begin
                n_bytes_left = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_DCR;
                end
                n_emit = 1'b1;
                n_kind = EV_ARG_DATA;
                n_pay  = data;
            end
            PH_DCR: begin
                if (data != CH_CR) begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_err   = ERR_BAD_CRLF;
                end else begin
                    n_phase = PH_DLF;
                end
            end
            PH_DLF: begin
                if (data != CH_LF) begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_err   = ERR_BAD_CRLF;
                end else begin
                    n_emit = 1'b1;
                    n_kind = EV_ARG_END;
                    if (next_arg >= r_args_total) begin
                        n_done    = 1'b1;
                        n_phase   = PH_STAR;
                        n_cur_arg = '0;
                    end else begin
                        n_phase   = PH_DOLLAR;
                        n_cur_arg = next_arg;
                    end
                end
            end
            PH_ERROR: begin
                n_phase = PH_ERROR;
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
    end

    // Hold parse state; advance it on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_STAR;
            r_args_total <= '0;
            r_cur_arg    <= '0;
            r_bytes_left <= '0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_args_total <= n_args_total;
            r_cur_arg    <= n_cur_arg;
            r_bytes_left <= n_bytes_left;
        end
    end

    // Output register valid: load on an event, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_kind <= n_kind;
            r_num  <= n_num;
            r_pay  <= n_pay;
            r_idx  <= n_idx;
            r_done <= n_done;
            r_err  <= n_err;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_kind   = r_kind;
    assign o_out.number_value = r_num;
    assign o_out.payload_byte = r_pay;
    assign o_out.arg_index    = r_idx;
    assign o_out.command_done = r_done;
    assign o_out.error_code   = r_err;

endmodule

>>> sv/rac_checker.sv
// Port-level assertions for the RESP array command parser, with the bind
// that attaches them to resp_array_command_parser. Depends on rac_pkg.
module rac_checker import rac_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic [30:0] i_num,
    input logic [7:0]  i_pay,
    input logic [30:0] i_idx,
    input logic        i_done,
    input logic [2:0]  i_err
);

    // A stalled event stays valid and holds its kind, number, index, done flag and code
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_num) && $stable(i_idx) && $stable(i_done) && $stable(i_err))
        else $error("stalled event changed");

    // A waiting byte is taken whenever the output register is empty
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // A header that completes the command carries a zero count
    a_empty_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == EV_HEADER) && i_done |-> (i_num == '0) && (i_idx == '0))
        else $error("completing header with non-zero count");

    // Error events carry nothing but the code and index
    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == EV_ERROR) |-> !i_done && (i_num == '0) && (i_pay == '0))
        else $error("error event with stray fields");

    // Only error events carry an error code
    a_err_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind != EV_ERROR) |-> (i_err == ERR_NO_ARRAY) && (i_kind <= EV_ERROR))
        else $error("non-error event with error code");

endmodule

bind resp_array_command_parser rac_checker u_rac_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_kind     (o_out.event_kind),
    .i_num      (o_out.number_value),
    .i_pay      (o_out.payload_byte),
    .i_idx      (o_out.arg_index),
    .i_done     (o_out.command_done),
    .i_err      (o_out.error_code)
);

>>> sim/testbench.sv
// Self-checking testbench for resp_array_command_parser.
// Depends on rac_pkg and rac_if; drives RESP command bytes, predicts each
// event in step with the byte channel and checks every event transaction.
`timescale 1ns / 100ps

module testbench;
    import rac_pkg::*;

    localparam int LINE_BYTES   = 64;
    localparam int BYTES_TARGET = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int PRINT_CAP    = 40;

    // Parser position within a command
    typedef enum logic [3:0] {
        WAIT_STAR, COUNT_LINE, COUNT_LF, WAIT_DOLLAR, LENGTH_LINE,
        LENGTH_LF, ARG_DATA, DATA_CR, DATA_LF, STUCK
    } t_parse_state;

    // Position within one number line
    typedef enum logic [1:0] {NUM_BLANKS, NUM_DIGITS, NUM_STOPPED} t_num_state;

    typedef struct {
        t_event_kind kind;
        t_num        number;
        logic [7:0]  payload;
        t_num        index;
        logic        done;
        t_err_code   code;
    } t_parse_event;

    logic clk;
    logic rst_n;
    logic no_idle;

    rac_byte_if  in_if ();
    rac_event_if out_if ();

    resp_array_command_parser #(.LINE_BUFFER_BYTES(LINE_BYTES)) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted parser state
    t_parse_state parse_state;
    t_num_state   num_state;
    int           line_count;
    logic [31:0]  num_acc;
    logic         num_neg;
    t_num         arg_total;
    t_num         arg_now;
    t_num         data_left;

    t_parse_event pending_events[$];
    int unsigned  mismatches;
    int unsigned  events_checked;
    int unsigned  bytes_taken;
    int unsigned  commands_sent;
    int unsigned  cycle_count;
    t_err_code    closing_fault;

    // Free-running clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a run that stops making progress
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d events outstanding",
                 cycle_count, pending_events.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] event %0d: %s", $time, events_checked, what);
    endtask

    function automatic void clear_number();
        line_count = 0;
        num_acc    = '0;
        num_neg    = 1'b0;
        num_state  = NUM_BLANKS;
    endfunction

    function automatic void reset_parser();
        parse_state = WAIT_STAR;
        clear_number();
        arg_total = '0;
        arg_now   = '0;
        data_left = '0;
    endfunction

    // Advance the predicted parser by one byte; return 1 when it yields an event
    function automatic bit parse_byte(input logic [7:0] b, output t_parse_event ev);
        bit          emitted;
        bit          faulted;
        bit          skip;
        t_err_code   fault;
        logic [63:0] grown;
        logic [63:0] ceiling;
        t_num        idx;

        emitted = 1'b0;
        faulted = 1'b0;
        skip    = 1'b0;
        fault   = ERR_NO_ARRAY;
        ev = '{kind: EV_HEADER, number: '0, payload: '0, index: '0, done: 1'b0,
               code: ERR_NO_ARRAY};
        case (parse_state)
            WAIT_STAR: begin
                if (b != CH_STAR) begin
                    faulted = 1'b1;
                    fault   = ERR_NO_ARRAY;
                end else begin
                    clear_number();
                    parse_state = COUNT_LINE;
                end
            end
            WAIT_DOLLAR: begin
                if (b != CH_DOLLAR) begin
                    faulted = 1'b1;
                    fault   = ERR_NO_BULK;
                end else begin
                    clear_number();
                    parse_state = LENGTH_LINE;
                end
            end
            COUNT_LINE, LENGTH_LINE: begin
                if (b == CH_CR) begin
                    parse_state = (parse_state == COUNT_LINE) ? COUNT_LF : LENGTH_LF;
                end else if (line_count >= LINE_BYTES - 1) begin
                    faulted = 1'b1;
                    fault   = ERR_LINE_LONG;
                end else begin
                    line_count++;
                    if (num_state == NUM_BLANKS) begin
                        if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
                            b == CH_FF) begin
                            skip = 1'b1;
                        end else if (b == CH_PLUS || b == CH_MINUS) begin
                            num_neg   = (b == CH_MINUS);
                            num_state = NUM_DIGITS;
                            skip      = 1'b1;
                        end else begin
                            num_state = NUM_DIGITS;
                        end
                    end
                    if (!skip && num_state == NUM_DIGITS) begin
                        if (b >= CH_ZERO && b <= CH_NINE) begin
                            grown   = {32'd0, num_acc} * 64'd10 + {56'd0, b - CH_ZERO};
                            ceiling = num_neg ? 64'(MAG_MAX_NEG) : 64'(MAG_MAX_POS);
                            if (grown > ceiling) begin
                                faulted = 1'b1;
                                fault   = ERR_OVERFLOW;
                            end else begin
                                num_acc = grown[31:0];
                            end
                        end else begin
                            num_state = NUM_STOPPED;
                        end
                    end
                end
            end
            COUNT_LF: begin
                if (b != CH_LF) begin
                    faulted = 1'b1;
                    fault   = ERR_BAD_CRLF;
                end else begin
                    arg_now = '0;
                    emitted = 1'b1;
                    ev.kind = EV_HEADER;
                    if (num_neg || num_acc == 0) begin
                        arg_total   = '0;
                        parse_state = WAIT_STAR;
                        ev.done     = 1'b1;
                    end else begin
                        arg_total   = num_acc[NUM_W-1:0];
                        parse_state = WAIT_DOLLAR;
                        ev.number   = arg_total;
                    end
                end
            end
            LENGTH_LF: begin
                if (b != CH_LF) begin
                    faulted = 1'b1;
                    fault   = ERR_BAD_CRLF;
                end else if (num_neg && num_acc != 0) begin
                    faulted = 1'b1;
                    fault   = ERR_NEG_LENGTH;
                end else begin
                    data_left   = num_acc[NUM_W-1:0];
                    parse_state = (data_left == 0) ? DATA_CR : ARG_DATA;
                    emitted     = 1'b1;
                    ev.kind     = EV_ARG_START;
                    ev.number   = data_left;
                    ev.index    = arg_now;
                end
            end
            ARG_DATA: begin
                data_left = data_left - 1'b1;
                if (data_left == 0)
                    parse_state = DATA_CR;
                emitted    = 1'b1;
                ev.kind    = EV_ARG_DATA;
                ev.payload = b;
                ev.index   = arg_now;
            end
            DATA_CR: begin
                if (b != CH_CR) begin
                    faulted = 1'b1;
                    fault   = ERR_BAD_CRLF;
                end else begin
                    parse_state = DATA_LF;
                end
            end
            DATA_LF: begin
                if (b != CH_LF) begin
                    faulted = 1'b1;
                    fault   = ERR_BAD_CRLF;
                end else begin
                    idx     = arg_now;
                    arg_now = arg_now + 1'b1;
                    emitted = 1'b1;
                    ev.kind  = EV_ARG_END;
                    ev.index = idx;
                    ev.done  = (arg_now >= arg_total);
                    if (ev.done) begin
                        parse_state = WAIT_STAR;
                        arg_now     = '0;
                    end else begin
                        parse_state = WAIT_DOLLAR;
                    end
                end
            end
            default: parse_state = STUCK;
        endcase

        // Any fault locks the parser until reset
        if (faulted) begin
            parse_state = STUCK;
            emitted  = 1'b1;
            ev.kind  = EV_ERROR;
            ev.index = arg_now;
            ev.code  = fault;
        end
        return emitted;
    endfunction

    // Compare one event transaction with the oldest prediction
    task automatic check_event();
        t_parse_event want;

        if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event kind %0d", out_if.event_kind));
        end else begin
            want = pending_events.pop_front();
            if (out_if.event_kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d",
                                          out_if.event_kind, want.kind));
            if (out_if.number_value !== want.number)
                report_mismatch($sformatf("number %0d, expected %0d",
                                          out_if.number_value, want.number));
            if (out_if.payload_byte !== want.payload)
                report_mismatch($sformatf("payload %h, expected %h",
                                          out_if.payload_byte, want.payload));
            if (out_if.arg_index !== want.index)
                report_mismatch($sformatf("arg index %0d, expected %0d",
                                          out_if.arg_index, want.index));
            if (out_if.command_done !== want.done)
                report_mismatch($sformatf("command done %b, expected %b",
                                          out_if.command_done, want.done));
            if (out_if.error_code !== want.code)
                report_mismatch($sformatf("error code %0d, expected %0d",
                                          out_if.error_code, want.code));
        end
        events_checked++;
    endtask

    // Predict on every byte transaction, check every event transaction
    always @(posedge clk) begin : channel_watch
        t_parse_event ev;

        if (rst_n === 1'b1) begin
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
                bytes_taken++;
                if (parse_byte(in_if.data_byte, ev))
                    pending_events.push_back(ev);
            end
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
                check_event();
        end
    end

    // Event sink: hold ready low for a random stall before each transaction, unless no_idle is set
    initial begin : event_sink
        int stall;

        out_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge clk); while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1));
        end
    end

    // Send one byte transaction after a random gap; valid stays high on return
    task automatic send_byte(input logic [7:0] b);
        int gap;

        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        do @(posedge clk); while (in_if.ready !== 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_crlf();
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // Decimal text for a number line, with optional blanks, sign, zeros and trailing junk
    function automatic string number_text(input longint value);
        logic [7:0] blanks [5] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF};
        string      s;
        longint     mag;
        logic [7:0] junk;
        int         n;

        s = "";
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) s = {s, $sformatf("%c", blanks[$urandom_range(0, 4)])};
        if (value < 0 || (value == 0 && $urandom_range(0, 3) == 0))
            s = {s, "-"};
        else if ($urandom_range(0, 3) == 0)
            s = {s, "+"};
        if ($urandom_range(0, 5) == 0)
            s = {s, "00"};
        mag = (value < 0) ? -value : value;
        s = {s, $sformatf("%0d", mag)};
        if ($urandom_range(0, 3) == 0) begin
            // first junk byte must end the digits
            do junk = 8'($urandom_range(1, 255));
            while (junk == CH_CR || (junk >= CH_ZERO && junk <= CH_NINE));
            s = {s, $sformatf("%c", junk)};
            repeat ($urandom_range(0, 2)) begin
                do junk = 8'($urandom_range(1, 255)); while (junk == CH_CR);
                s = {s, $sformatf("%c", junk)};
            end
        end
        return s;
    endfunction

    // One complete bulk string: length line, data and closing CRLF
    task automatic send_argument(input int len);
        send_byte(CH_DOLLAR);
        send_text(number_text(len));
        send_crlf();
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        send_crlf();
    endtask

    // Counts of zero or less, empty and non-numeric count lines
    task automatic test_empty_commands();
        send_text("*0");
        send_crlf();
        send_text("*-7");
        send_crlf();
        send_text("*-0");
        send_crlf();
        send_byte(CH_STAR);
        send_crlf();
        send_text("*x9");
        send_crlf();
        send_text("*-2147483648");
        send_crlf();
    endtask

    // Whitespace, signs, junk, zero lengths and extreme data bytes
    task automatic test_argument_forms();
        send_byte(CH_STAR);
        send_byte(CH_SPACE);
        send_byte(CH_TAB);
        send_byte(CH_LF);
        send_byte(CH_VT);
        send_byte(CH_FF);
        send_text("+3z");
        send_crlf();
        send_text("$-0");
        send_crlf();
        send_crlf();
        send_text("$ 007;7");
        send_crlf();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_STAR);
        send_byte(CH_DOLLAR);
        send_byte(8'h80);
        send_crlf();
        send_byte(CH_DOLLAR);
        send_crlf();
        send_crlf();
    endtask

    // Number lines at the longest length that is still accepted
    task automatic test_longest_lines();
        send_byte(CH_STAR);
        repeat (LINE_BYTES - 3) send_byte(CH_SPACE);
        send_text("02");
        send_crlf();
        send_byte(CH_DOLLAR);
        send_byte(CH_PLUS);
        repeat (LINE_BYTES - 3) send_byte(CH_ZERO);
        send_text("2");
        send_crlf();
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_crlf();
        send_argument(1);
    endtask

    // Well-formed commands with random shape and content
    task automatic test_random_commands();
        int     nargs;
        longint count;

        while (bytes_taken < BYTES_TARGET) begin
            no_idle = ($urandom_range(0, 4) == 0);
            commands_sent++;
            send_byte(CH_STAR);
            if ($urandom_range(0, 9) == 0) begin
                count = ($urandom_range(0, 7) == 0) ? -64'sd2147483648
                                                     : -longint'($urandom_range(0, 50));
                send_text(number_text(count));
                send_crlf();
            end else begin
                nargs = $urandom_range(1, 4);
                send_text(number_text(nargs));
                send_crlf();
                repeat (nargs)
                    send_argument(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                              : $urandom_range(0, 12));
            end
        end
        no_idle = 1'b0;
    endtask

    // One randomly chosen fault, then bytes that must be ignored
    task automatic test_sticky_error();
        logic [7:0] b;

        closing_fault = t_err_code'($urandom_range(0, 5));
        if (closing_fault == ERR_NO_ARRAY) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_STAR);
            send_byte(b);
        end else begin
            // widest count, so the command never completes on its own
            send_text("*2147483647");
            send_crlf();
            repeat ($urandom_range(0, 2)) send_argument($urandom_range(0, 6));
            case (closing_fault)
                ERR_NO_BULK: begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_DOLLAR);
                    send_byte(b);
                end
                ERR_NEG_LENGTH: begin
                    send_byte(CH_DOLLAR);
                    send_text(number_text(($urandom_range(0, 3) == 0) ? -64'sd2147483648
                                          : -longint'($urandom_range(1, 1000))));
                    send_crlf();
                end
                ERR_BAD_CRLF: begin
                    case ($urandom_range(0, 2))
                        0: begin
                            send_text("$3");
                            send_byte(CH_CR);
                        end
                        1: begin
                            send_text("$2");
                            send_crlf();
                            repeat (2) send_byte(8'($urandom_range(0, 255)));
                        end
                        default: begin
                            send_text("$1");
                            send_crlf();
                            send_byte(8'($urandom_range(0, 255)));
                            send_byte(CH_CR);
                        end
                    endcase
                    do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
                    send_byte(b);
                end
                ERR_LINE_LONG: begin
                    send_text("$7q");
                    repeat (LINE_BYTES - 2) begin
                        do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
                        send_byte(b);
                    end
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0:       send_text("$2147483648");
                        1:       send_text("$-2147483649");
                        default: send_text("$ +99999999999");
                    endcase
                end
            endcase
        end
        repeat (20) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        mismatches     = 0;
        events_checked = 0;
        bytes_taken    = 0;
        commands_sent  = 0;
        no_idle        = 1'b0;
        reset_parser();
        rst_n           <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_commands();
        test_argument_forms();
        test_longest_lines();
        test_random_commands();
        test_sticky_error();
        in_if.valid <= 1'b0;

        // Drain outstanding events, then watch for stray ones
        while (pending_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d random commands plus directed ones; %0d events checked",
                 bytes_taken, commands_sent, events_checked);
        $display("Run closed on sticky error %s, %0d mismatches", closing_fault.name(),
                 mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
